// ===== design/drd_pkg.sv =====
// Package for the detection row decode unit: fixed-point constants, register
// indexes and reset values, and the structs shared by the row accumulator
// and the top level. Depends on nothing.
`default_nettype none

package drd_pkg;

  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned MAX_CLASSES = 256;
  localparam int unsigned OBJ_INDEX   = 4;
  localparam int unsigned FIRST_CLASS = 5;
  localparam int unsigned INDEX_MAX   = 511;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_THRESHOLD   = 3'd0,
    REG_CLASS_THRESHOLD = 3'd1,
    REG_CLASS_COUNT     = 3'd2,
    REG_RATIO_W         = 3'd3,
    REG_RATIO_H         = 3'd4,
    REG_IMAGE_COLS      = 3'd5,
    REG_IMAGE_ROWS      = 3'd6
  } drd_reg_e;

  localparam logic [12:0] RST_BOX_THRESHOLD   = 13'd2048;
  localparam logic [12:0] RST_CLASS_THRESHOLD = 13'd2048;
  localparam logic [8:0]  RST_CLASS_COUNT     = 9'd80;
  localparam logic [15:0] RST_RATIO_W         = 16'd4096;
  localparam logic [15:0] RST_RATIO_H         = 16'd4096;
  localparam logic [12:0] RST_IMAGE_COLS      = 13'd640;
  localparam logic [12:0] RST_IMAGE_ROWS      = 13'd640;

  typedef struct packed {
    logic [12:0] box_threshold;
    logic [12:0] class_threshold;
    logic [8:0]  class_count;
    logic [15:0] ratio_w;
    logic [15:0] ratio_h;
    logic [12:0] image_cols;
    logic [12:0] image_rows;
  } drd_cfg_t;

  // Row contents as they stand once the final beat has been folded in.
  typedef struct packed {
    logic [3:0][23:0] box;
    logic [23:0]      obj;
    logic [23:0]      best;
    logic [7:0]       cls;
  } drd_row_t;

endpackage

`default_nettype wire

// ===== design/drd_row_acc.sv =====
// Row accumulator: collects box fields, objectness and the running best
// class score beat by beat and decides at row end whether to keep the row.
// Depends on drd_pkg.
`default_nettype none

module drd_row_acc import drd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  logic signed [23:0] elem_value_i,
  input  logic               row_last_i,
  input  drd_cfg_t           cfg_i,
  output drd_row_t           row_o,
  output logic               keep_o
);

  logic [8:0]         idx_q;
  logic [3:0][23:0]   box_q, box_d;
  logic signed [23:0] obj_q, obj_d;
  logic signed [23:0] best_q, best_d;
  logic [7:0]         cls_q, cls_d;
  logic [8:0]         n_cls;
  logic [8:0]         cls_off;
  logic               seen;
  logic               obj_ok;
  logic               best_ok;

  assign n_cls   = (cfg_i.class_count > 9'(MAX_CLASSES)) ? 9'(MAX_CLASSES) : cfg_i.class_count;
  assign cls_off = idx_q - 9'(FIRST_CLASS);

  always_comb begin
    box_d  = box_q;
    obj_d  = obj_q;
    best_d = best_q;
    cls_d  = cls_q;
    if (idx_q < 9'(OBJ_INDEX)) begin
      box_d[idx_q[1:0]] = elem_value_i;
    end else if (idx_q == 9'(OBJ_INDEX)) begin
      obj_d = elem_value_i;
    end else if (cls_off < n_cls) begin
      if (idx_q == 9'(FIRST_CLASS) || elem_value_i > best_q) begin
        best_d = elem_value_i;
        cls_d  = cls_off[7:0];
      end
    end
  end

  assign seen    = (n_cls != 9'd0) && (idx_q >= 9'(FIRST_CLASS));
  assign obj_ok  = $signed({obj_d[23], obj_d}) >= $signed({12'b0, cfg_i.box_threshold});
  assign best_ok = $signed({best_d[23], best_d}) >= $signed({12'b0, cfg_i.class_threshold});
  assign keep_o  = seen && obj_ok && best_ok;

  assign row_o.box  = box_d;
  assign row_o.obj  = obj_d;
  assign row_o.best = best_d;
  assign row_o.cls  = cls_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      box_q  <= '0;
      obj_q  <= '0;
      best_q <= '0;
      cls_q  <= '0;
    end else if (beat_i) begin
      if (row_last_i) begin
        idx_q  <= '0;
        box_q  <= '0;
        obj_q  <= '0;
        best_q <= '0;
        cls_q  <= '0;
      end else begin
        if (idx_q < 9'(INDEX_MAX)) begin
          idx_q <= idx_q + 9'd1;
        end
        box_q  <= box_d;
        obj_q  <= obj_d;
        best_q <= best_d;
        cls_q  <= cls_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/detection_row_decode_unit.sv =====
// Top level of the detection row decode unit: configuration registers, the
// row accumulator and a four-stage result pipeline. Depends on drd_pkg and
// drd_row_acc.
`default_nettype none

// The unit takes one row element per cycle in signed Q12.12 and, on the beat
// marked last, may produce one detection. A result passes stages A, B, C and
// the output stage after the last beat of its row; every stage holds one row,
// so rows may follow each other beat after beat and one element is accepted
// in every cycle as long as the consumer keeps up. The rate is set by the row
// accumulator, which folds one element per clock into its running state.
// Configuration writes take effect at once and belong to idle periods.

module detection_row_decode_unit import drd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [23:0]    elem_value_i,
  input  logic                  row_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            class_id_o,
  output logic [12:0]           confidence_o,
  output logic [15:0]           box_left_o,
  output logic [15:0]           box_top_o,
  output logic [12:0]           box_width_o,
  output logic [12:0]           box_height_o
);

  localparam int unsigned EDGE_SH = 2 * FRAC_BITS + 1;
  localparam int unsigned EXT_SH  = 2 * FRAC_BITS;
  localparam int unsigned EXT_W   = 42 - EXT_SH;

  drd_cfg_t cfg_q;
  drd_row_t row;
  logic     keep;
  logic     beat;

  logic     a_v_q, b_v_q, c_v_q, out_valid_q;
  logic     a_rdy, b_rdy, c_rdy, o_rdy;

  drd_row_t a_row_q;

  logic [7:0]         b_cls_q;
  logic [45:0]        b_conf_q;
  logic signed [42:0] b_lp_q, b_tp_q;
  logic signed [40:0] b_wp_q, b_hp_q;
  logic signed [25:0] dx, dy;

  logic [7:0]             c_cls_q;
  logic [12:0]            c_conf_q;
  logic [15:0]            c_left_q, c_top_q;
  logic signed [EXT_W-1:0] c_wr_q, c_hr_q;
  logic [46:0]            conf_sum, conf_sh;
  logic signed [43:0]     lp_r, tp_r;
  logic signed [41:0]     wp_r, hp_r;
  logic [15:0]            left_c, top_c;

  logic signed [31:0] room_w, room_h, wr32, hr32, wd, ht;
  logic [7:0]  class_id_q;
  logic [12:0] confidence_q, box_width_q, box_height_q;
  logic [15:0] box_left_q, box_top_q;

  function automatic logic [15:0] clamp_edge(input logic signed [43:0] v);
    logic [15:0] r;
    if (v < 0) begin
      r = 16'd0;
    end else if (v > 44'sd65535) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_threshold   <= RST_BOX_THRESHOLD;
      cfg_q.class_threshold <= RST_CLASS_THRESHOLD;
      cfg_q.class_count     <= RST_CLASS_COUNT;
      cfg_q.ratio_w         <= RST_RATIO_W;
      cfg_q.ratio_h         <= RST_RATIO_H;
      cfg_q.image_cols      <= RST_IMAGE_COLS;
      cfg_q.image_rows      <= RST_IMAGE_ROWS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_THRESHOLD:   cfg_q.box_threshold   <= cfg_wdata_i[12:0];
        REG_CLASS_THRESHOLD: cfg_q.class_threshold <= cfg_wdata_i[12:0];
        REG_CLASS_COUNT:     cfg_q.class_count     <= cfg_wdata_i[8:0];
        REG_RATIO_W:         cfg_q.ratio_w         <= cfg_wdata_i;
        REG_RATIO_H:         cfg_q.ratio_h         <= cfg_wdata_i;
        REG_IMAGE_COLS:      cfg_q.image_cols      <= cfg_wdata_i[12:0];
        REG_IMAGE_ROWS:      cfg_q.image_rows      <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  assign o_rdy      = !out_valid_q || out_ready_i;
  assign c_rdy      = !c_v_q || o_rdy;
  assign b_rdy      = !b_v_q || c_rdy;
  assign a_rdy      = !a_v_q || b_rdy;
  assign in_ready_o = a_rdy;
  assign beat       = in_valid_i && a_rdy;

  drd_row_acc u_row_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .elem_value_i (elem_value_i),
    .row_last_i   (row_last_i),
    .cfg_i        (cfg_q),
    .row_o        (row),
    .keep_o       (keep)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      c_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= beat && row_last_i && keep;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (o_rdy) out_valid_q <= c_v_q;
    end
  end

  // Stage A: snapshot of every row at its final beat; only kept rows are valid.
  always_ff @(posedge clk_i) begin
    if (beat && row_last_i) begin
      a_row_q <= row;
    end
  end

  // Stage B: confidence product and the four box products.
  assign dx = $signed({a_row_q.box[0][23], a_row_q.box[0], 1'b0})
            - $signed({{2{a_row_q.box[2][23]}}, a_row_q.box[2]});
  assign dy = $signed({a_row_q.box[1][23], a_row_q.box[1], 1'b0})
            - $signed({{2{a_row_q.box[3][23]}}, a_row_q.box[3]});

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_v_q) begin
      b_cls_q  <= a_row_q.cls;
      b_conf_q <= 46'(a_row_q.best[22:0]) * 46'(a_row_q.obj[22:0]);
      b_lp_q   <= dx * $signed({1'b0, cfg_q.ratio_w});
      b_tp_q   <= dy * $signed({1'b0, cfg_q.ratio_h});
      b_wp_q   <= $signed(a_row_q.box[2]) * $signed({1'b0, cfg_q.ratio_w});
      b_hp_q   <= $signed(a_row_q.box[3]) * $signed({1'b0, cfg_q.ratio_h});
    end
  end

  // Stage C: rounding, saturation of confidence and edges.
  assign conf_sum = {1'b0, b_conf_q} + 47'(1 << (FRAC_BITS - 1));
  assign conf_sh  = conf_sum >> FRAC_BITS;
  assign lp_r     = (44'(b_lp_q) + 44'sd1 * 44'(1 << (2 * FRAC_BITS))) >>> EDGE_SH;
  assign tp_r     = (44'(b_tp_q) + 44'sd1 * 44'(1 << (2 * FRAC_BITS))) >>> EDGE_SH;
  assign wp_r     = (42'(b_wp_q) + 42'sd1 * 42'(1 << (2 * FRAC_BITS - 1))) >>> EXT_SH;
  assign hp_r     = (42'(b_hp_q) + 42'sd1 * 42'(1 << (2 * FRAC_BITS - 1))) >>> EXT_SH;
  assign left_c   = clamp_edge(lp_r);
  assign top_c    = clamp_edge(tp_r);

  always_ff @(posedge clk_i) begin
    if (c_rdy && b_v_q) begin
      c_cls_q  <= b_cls_q;
      c_conf_q <= (conf_sh > 47'(1 << FRAC_BITS)) ? 13'(1 << FRAC_BITS) : conf_sh[12:0];
      c_left_q <= left_c;
      c_top_q  <= top_c;
      c_wr_q   <= wp_r[EXT_W-1:0];
      c_hr_q   <= hp_r[EXT_W-1:0];
    end
  end

  // Output stage: extents limited to the room left in the image.
  assign room_w = $signed({19'b0, cfg_q.image_cols}) - $signed({16'b0, c_left_q});
  assign room_h = $signed({19'b0, cfg_q.image_rows}) - $signed({16'b0, c_top_q});
  assign wr32   = 32'(c_wr_q);
  assign hr32   = 32'(c_hr_q);

  always_comb begin
    wd = (wr32 > room_w) ? room_w : wr32;
    if (wd < 0) wd = '0;
    ht = (hr32 > room_h) ? room_h : hr32;
    if (ht < 0) ht = '0;
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && c_v_q) begin
      class_id_q   <= c_cls_q;
      confidence_q <= c_conf_q;
      box_left_q   <= c_left_q;
      box_top_q    <= c_top_q;
      box_width_q  <= wd[12:0];
      box_height_q <= ht[12:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign class_id_o   = class_id_q;
  assign confidence_o = confidence_q;
  assign box_left_o   = box_left_q;
  assign box_top_o    = box_top_q;
  assign box_width_o  = box_width_q;
  assign box_height_o = box_height_q;

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_v_q && b_v_q && c_v_q && out_valid_q))
    else $error("input stalled while a pipeline stage is free");

  a_conf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (confidence_o <= 13'(1 << FRAC_BITS)))
    else $error("confidence above saturation limit");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !c_v_q) |=> !out_valid_o)
    else $error("result repeated after its beat was taken");

endmodule

`default_nettype wire
